// ===== design/bwb_pkg.sv =====
`timescale 1ns / 1ps

package bwb_pkg;

    // field widths
    localparam int TIME_W     = 24;
    localparam int AMP_W      = 24;
    localparam int IDX_W      = 25;
    localparam int OFS_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Q8.16 unity is one shifted left by this much
    localparam int UNITY_SHIFT = 16;

    // defaults
    localparam int DEF_MAX_POINTS  = 32;
    localparam int DEF_TABLE_DEPTH = 32768;
    localparam int DEF_TABLE_SIZE  = 512;

    // request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESCALE_ENABLE = 2'd2;

    typedef struct packed {
        logic                     req_type;
        logic [TIME_W-1:0]        point_time;
        logic signed [AMP_W-1:0]  point_amp;
        logic                     last_point;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         entry_index;
        logic signed [AMP_W-1:0]  entry_amp;
        logic                     last_entry;
    } rsp_t;

endpackage

// ===== design/breakpoint_wavetable_builder.sv =====
`timescale 1ns / 1ps

// Fetch: the table memory (single read port) registers the entry, then the output
// register presents it on rsp; no new fetch is taken while one is pending or rsp stalls.
// Load: a load with last_point builds the table: it clears the table, then divides
// for each segment's start position and for each entry's value, then with rescaling
// searches the peak and scales every entry by it (one shared divider).
// Reset clears control state only; memory contents stay undefined, no clearing pass.
module breakpoint_wavetable_builder #(
    parameter int MAX_POINTS  = bwb_pkg::DEF_MAX_POINTS,
    parameter int TABLE_DEPTH = bwb_pkg::DEF_TABLE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  bwb_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output bwb_pkg::rsp_t                       rsp,
    input  logic                                cfg_we,
    input  logic [bwb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bwb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bwb_pkg::*;

    // widths derived from the parameters
    localparam int PAW   = $clog2(MAX_POINTS);        // breakpoint address
    localparam int CW    = $clog2(MAX_POINTS + 1);    // breakpoint count
    localparam int AW    = $clog2(TABLE_DEPTH);       // table address
    localparam int SW    = $clog2(TABLE_DEPTH + 1);   // table size / position
    localparam int MW    = (SW > UNITY_SHIFT) ? SW : UNITY_SHIFT;
    localparam int DIV_W = AMP_W + 1 + MW;            // divider operand width
    localparam int DCW   = $clog2(DIV_W + 1);
    localparam int DEF_SIZE = (DEF_TABLE_SIZE > TABLE_DEPTH) ? TABLE_DEPTH : DEF_TABLE_SIZE;

    // build sequencer states
    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_CLEAR = 5'd1;   // zero the table
    localparam logic [4:0] ST_TLRD  = 5'd2;   // read last breakpoint time
    localparam logic [4:0] ST_TLWT  = 5'd3;
    localparam logic [4:0] ST_SEG   = 5'd4;   // segment head: read earlier point
    localparam logic [4:0] ST_SEGB  = 5'd5;   // read later point
    localparam logic [4:0] ST_SEGC  = 5'd6;   // scale later time by table size
    localparam logic [4:0] ST_SEGD  = 5'd7;   // start position division
    localparam logic [4:0] ST_PDIV  = 5'd8;
    localparam logic [4:0] ST_SEGE  = 5'd9;   // segment bounds
    localparam logic [4:0] ST_EMUL  = 5'd10;  // entry numerator
    localparam logic [4:0] ST_EDST  = 5'd11;
    localparam logic [4:0] ST_EDIV  = 5'd12;
    localparam logic [4:0] ST_EWR   = 5'd13;  // write interpolated entry
    localparam logic [4:0] ST_PKA   = 5'd14;  // peak search read
    localparam logic [4:0] ST_PKB   = 5'd15;  // peak search compare
    localparam logic [4:0] ST_SCL0  = 5'd16;
    localparam logic [4:0] ST_SCA   = 5'd17;  // rescale read
    localparam logic [4:0] ST_SCB   = 5'd18;  // rescale divide start
    localparam logic [4:0] ST_SCD   = 5'd19;
    localparam logic [4:0] ST_SCW   = 5'd20;  // rescale write back

    // memories
    logic [TIME_W-1:0] bp_times [MAX_POINTS];
    logic [AMP_W-1:0]  bp_amps  [MAX_POINTS];
    logic [AMP_W-1:0]  wave_mem [TABLE_DEPTH];

    logic              bp_we;
    logic [PAW-1:0]    bp_waddr;
    logic [PAW-1:0]    bp_raddr;
    logic [TIME_W-1:0] bp_t_q;
    logic [AMP_W-1:0]  bp_a_q;
    logic              wt_we;
    logic [AW-1:0]     wt_waddr;
    logic [AMP_W-1:0]  wt_wdata;
    logic [AW-1:0]     wt_raddr;
    logic [AMP_W-1:0]  wt_q;

    // control and datapath registers
    logic [4:0]        state_reg, state_next;
    logic [CW-1:0]     pcount_reg, pcount_next;
    logic [CW-1:0]     npts_reg, npts_next;
    logic [CW-1:0]     p_reg, p_next;
    logic [SW-1:0]     cnt_reg, cnt_next;
    logic [SW-1:0]     size_reg, size_next;
    logic [OFS_W-1:0]  bofs_reg, bofs_next;
    logic              rescale_reg, rescale_next;
    logic [SW-1:0]     rp_reg, rp_next;
    logic              tvalid_reg, tvalid_next;
    logic              pend_reg, pend_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [DCW-1:0]    div_cnt_reg, div_cnt_next;

    logic [TIME_W-1:0] tlast_reg, tlast_next;
    logic [AMP_W-1:0]  a1_reg, a1_next;
    logic [AMP_W-1:0]  a2_reg, a2_next;
    logic [DIV_W-1:0]  pmul_reg, pmul_next;
    logic [DIV_W-1:0]  pos_reg, pos_next;
    logic [DIV_W-1:0]  prev_end_reg, prev_end_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [SW-1:0]     start_lo_reg, start_lo_next;
    logic [SW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     l_reg, l_next;
    logic              d_neg_reg, d_neg_next;
    logic [AMP_W:0]    d_mag_reg, d_mag_next;
    logic [DIV_W-1:0]  prod_reg, prod_next;
    logic [AMP_W-1:0]  peak_reg, peak_next;
    logic              v_neg_reg, v_neg_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              pend_last_reg, pend_last_next;
    rsp_t              rsp_reg, rsp_next;
    logic [DIV_W-1:0]  div_quo_reg, div_quo_next;
    logic [DIV_W-1:0]  div_rem_reg, div_rem_next;
    logic [DIV_W-1:0]  div_dvs_reg, div_dvs_next;

    // divider launch
    logic              div_start;
    logic [DIV_W-1:0]  div_dvd;
    logic [DIV_W-1:0]  div_dvs;

    // combinational helpers
    logic              req_xfer;
    logic              stored;
    logic [CW-1:0]     pcount_inc;
    logic [SW-1:0]     rp_eff;
    logic              rp_last;
    logic [SW:0]       cfg_size_ext;
    logic [DIV_W-1:0]  end_v;
    logic [DIV_W-1:0]  start_v;
    logic [DIV_W-1:0]  size_ext;
    logic [AMP_W:0]    d_v;
    logic [AMP_W-1:0]  wt_mag;
    logic [AMP_W+1:0]  q_ext;
    logic [AMP_W+1:0]  q_signed;
    logic [AMP_W+1:0]  interp_v;
    logic [DIV_W:0]    div_shift;
    logic [DIV_W:0]    div_diff;
    logic              size_end;

    assign req_ready = (state_reg == ST_IDLE) && !pend_reg && (!rsp_valid_reg || rsp_ready);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // breakpoint store: one write, one read per cycle
    always_ff @(posedge clk)
    begin
        if (bp_we)
        begin
            bp_times[bp_waddr] <= req.point_time;
            bp_amps[bp_waddr]  <= req.point_amp;
        end
        bp_t_q <= bp_times[bp_raddr];
        bp_a_q <= bp_amps[bp_raddr];
    end

    // wave table: one write, one read per cycle
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wave_mem[wt_waddr] <= wt_wdata;
        end
        wt_q <= wave_mem[wt_raddr];
    end

    // fetch position, wrapped if the size shrank below it
    assign rp_eff  = (rp_reg >= size_reg) ? '0 : rp_reg;
    assign rp_last = (SW'(rp_eff + 1'b1) == size_reg);

    assign stored     = (pcount_reg < CW'(MAX_POINTS));
    assign pcount_inc = stored ? CW'(pcount_reg + 1'b1) : pcount_reg;

    assign cfg_size_ext = (SW + 1)'(cfg_data);
    assign size_ext     = DIV_W'(size_reg);
    assign size_end     = (cnt_reg == SW'(size_reg - 1'b1));

    // segment bounds
    assign end_v   = DIV_W'(pos_reg + 1'b1);
    assign start_v = DIV_W'(prev_end_reg + 1'b1);

    // amplitude step and magnitudes
    assign d_v    = (AMP_W + 1)'({a2_reg[AMP_W-1], a2_reg} - {a1_reg[AMP_W-1], a1_reg});
    assign wt_mag = wt_q[AMP_W-1] ? AMP_W'(~wt_q + 1'b1) : wt_q;

    // interpolated value: a1 plus the signed quotient
    assign q_ext    = {1'b0, div_quo_reg[AMP_W:0]};
    assign q_signed = d_neg_reg ? (AMP_W + 2)'(~q_ext + 1'b1) : q_ext;
    assign interp_v = (AMP_W + 2)'({{2{a1_reg[AMP_W-1]}}, a1_reg} + q_signed);

    // restoring divider step, one quotient bit a cycle
    assign div_shift = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign div_diff  = (DIV_W + 1)'(div_shift - {1'b0, div_dvs_reg});

    always_comb
    begin
        div_quo_next = div_quo_reg;
        div_rem_next = div_rem_reg;
        div_dvs_next = div_dvs_reg;
        div_cnt_next = div_cnt_reg;
        if (div_start)
        begin
            div_quo_next = div_dvd;
            div_rem_next = '0;
            div_dvs_next = div_dvs;
            div_cnt_next = DCW'(DIV_W);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_next = DCW'(div_cnt_reg - 1'b1);
            if (!div_diff[DIV_W])
            begin
                div_rem_next = div_diff[DIV_W-1:0];
                div_quo_next = {div_quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = div_shift[DIV_W-1:0];
                div_quo_next = {div_quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    // main sequencer
    always_comb
    begin
        state_next     = state_reg;
        pcount_next    = pcount_reg;
        npts_next      = npts_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        size_next      = size_reg;
        bofs_next      = bofs_reg;
        rescale_next   = rescale_reg;
        rp_next        = rp_reg;
        tvalid_next    = tvalid_reg;
        pend_next      = 1'b0;
        rsp_valid_next = rsp_valid_reg;
        tlast_next     = tlast_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        pmul_next      = pmul_reg;
        pos_next       = pos_reg;
        prev_end_next  = prev_end_reg;
        den_next       = den_reg;
        start_lo_next  = start_lo_reg;
        hi_next        = hi_reg;
        l_next         = l_reg;
        d_neg_next     = d_neg_reg;
        d_mag_next     = d_mag_reg;
        prod_next      = prod_reg;
        peak_next      = peak_reg;
        v_neg_next     = v_neg_reg;
        pend_idx_next  = pend_idx_reg;
        pend_last_next = pend_last_reg;
        rsp_next       = rsp_reg;

        bp_we     = 1'b0;
        bp_waddr  = pcount_reg[PAW-1:0];
        bp_raddr  = p_reg[PAW-1:0];
        wt_we     = 1'b0;
        wt_waddr  = cnt_reg[AW-1:0];
        wt_wdata  = '0;
        wt_raddr  = (state_reg == ST_IDLE) ? rp_eff[AW-1:0] : cnt_reg[AW-1:0];
        div_start = 1'b0;
        div_dvd   = pmul_reg;
        div_dvs   = DIV_W'(tlast_reg);

        // output register: drop on transfer, load when a fetch read lands
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (pend_reg)
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.entry_index = pend_idx_reg;
            rsp_next.entry_amp   = wt_q;
            rsp_next.last_entry  = pend_last_reg;
        end

        // configuration writes; the host must issue them only while idle; the block itself does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TABLE_SIZE:
                begin
                    if (cfg_size_ext == '0)
                    begin
                        size_next = SW'(1);
                    end
                    else if (32'(cfg_size_ext) > TABLE_DEPTH)
                    begin
                        size_next = SW'(TABLE_DEPTH);
                    end
                    else
                    begin
                        size_next = SW'(cfg_size_ext);
                    end
                    tvalid_next = 1'b0;
                    rp_next     = '0;
                end
                REG_BLOCK_OFFSET:   bofs_next    = cfg_data[OFS_W-1:0];
                REG_RESCALE_ENABLE: rescale_next = cfg_data[0];
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && req.req_type == REQ_LOAD)
                begin
                    bp_we       = stored;
                    pcount_next = pcount_inc;
                    if (req.last_point && pcount_inc != '0)
                    begin
                        npts_next   = pcount_inc;
                        pcount_next = '0;
                        rp_next     = '0;
                        tvalid_next = 1'b0;
                        cnt_next    = '0;
                        state_next  = ST_CLEAR;
                    end
                end
                else if (req_xfer && tvalid_reg)
                begin
                    // issue the table read; the entry lands next cycle
                    pend_next      = 1'b1;
                    pend_idx_next  = IDX_W'(IDX_W'(rp_eff) + IDX_W'(bofs_reg) * IDX_W'(size_reg));
                    pend_last_next = rp_last;
                    rp_next        = rp_last ? '0 : SW'(rp_eff + 1'b1);
                end
            end

            ST_CLEAR:
            begin
                wt_we = 1'b1;
                if (size_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_TLRD;
                end
                else
                begin
                    cnt_next = SW'(cnt_reg + 1'b1);
                end
            end

            ST_TLRD:
            begin
                bp_raddr   = PAW'(npts_reg - 1'b1);
                state_next = ST_TLWT;
            end

            ST_TLWT:
            begin
                tlast_next    = bp_t_q;
                p_next        = '0;
                prev_end_next = '0;
                state_next    = ST_SEG;
            end

            ST_SEG:
            begin
                if (CW'(p_reg + 1'b1) < npts_reg)
                begin
                    state_next = ST_SEGB;
                end
                else if (rescale_reg)
                begin
                    cnt_next   = '0;
                    peak_next  = '0;
                    state_next = ST_PKA;
                end
                else
                begin
                    tvalid_next = 1'b1;
                    rp_next     = '0;
                    state_next  = ST_IDLE;
                end
            end

            ST_SEGB:
            begin
                bp_raddr   = PAW'(p_reg + 1'b1);
                a1_next    = bp_a_q;
                state_next = ST_SEGC;
            end

            ST_SEGC:
            begin
                a2_next    = bp_a_q;
                pmul_next  = DIV_W'(bp_t_q) * size_ext;
                state_next = ST_SEGD;
            end

            ST_SEGD:
            begin
                d_neg_next = d_v[AMP_W];
                d_mag_next = d_v[AMP_W] ? (AMP_W + 1)'(~d_v + 1'b1) : d_v;
                if (tlast_reg == '0)
                begin
                    // zero last time: the segment ends past the table
                    pos_next   = size_ext;
                    state_next = ST_SEGE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_PDIV;
                end
            end

            ST_PDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    pos_next   = div_quo_reg;
                    state_next = ST_SEGE;
                end
            end

            ST_SEGE:
            begin
                prev_end_next = end_v;
                den_next      = DIV_W'(end_v - start_v + 1'b1);
                hi_next       = (end_v < size_ext) ? SW'(end_v) : size_reg;
                start_lo_next = SW'(start_v);
                l_next        = SW'(start_v);
                if (start_v <= end_v && start_v <= size_ext)
                begin
                    state_next = ST_EMUL;
                end
                else
                begin
                    // empty or reversed segment, or one that starts past the table
                    p_next     = CW'(p_reg + 1'b1);
                    state_next = ST_SEG;
                end
            end

            ST_EMUL:
            begin
                prod_next  = DIV_W'(d_mag_reg) * DIV_W'(SW'(l_reg - start_lo_reg));
                state_next = ST_EDST;
            end

            ST_EDST:
            begin
                div_start  = 1'b1;
                div_dvd    = prod_reg;
                div_dvs    = den_reg;
                state_next = ST_EDIV;
            end

            ST_EDIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_EWR;
                end
            end

            ST_EWR:
            begin
                wt_we    = 1'b1;
                wt_waddr = AW'(l_reg - 1'b1);
                wt_wdata = interp_v[AMP_W-1:0];
                if (l_reg == hi_reg)
                begin
                    p_next     = CW'(p_reg + 1'b1);
                    state_next = ST_SEG;
                end
                else
                begin
                    l_next     = SW'(l_reg + 1'b1);
                    state_next = ST_EMUL;
                end
            end

            ST_PKA:
            begin
                state_next = ST_PKB;
            end

            ST_PKB:
            begin
                if (wt_mag > peak_reg)
                begin
                    peak_next = wt_mag;
                end
                if (size_end)
                begin
                    cnt_next   = '0;
                    state_next = ST_SCL0;
                end
                else
                begin
                    cnt_next   = SW'(cnt_reg + 1'b1);
                    state_next = ST_PKA;
                end
            end

            ST_SCL0:
            begin
                if (peak_reg == '0)
                begin
                    // all-zero table: leave it unscaled
                    tvalid_next = 1'b1;
                    rp_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_SCA;
                end
            end

            ST_SCA:
            begin
                state_next = ST_SCB;
            end

            ST_SCB:
            begin
                v_neg_next = wt_q[AMP_W-1];
                div_start  = 1'b1;
                div_dvd    = DIV_W'(wt_mag) << UNITY_SHIFT;
                div_dvs    = DIV_W'(peak_reg);
                state_next = ST_SCD;
            end

            ST_SCD:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_SCW;
                end
            end

            ST_SCW:
            begin
                wt_we    = 1'b1;
                wt_wdata = v_neg_reg ? AMP_W'(~div_quo_reg[AMP_W-1:0] + 1'b1)
                                     : div_quo_reg[AMP_W-1:0];
                if (size_end)
                begin
                    tvalid_next = 1'b1;
                    rp_next     = '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cnt_next   = SW'(cnt_reg + 1'b1);
                    state_next = ST_SCA;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pcount_reg    <= '0;
            npts_reg      <= '0;
            p_reg         <= '0;
            cnt_reg       <= '0;
            size_reg      <= SW'(DEF_SIZE);
            bofs_reg      <= '0;
            rescale_reg   <= 1'b1;
            rp_reg        <= '0;
            tvalid_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pcount_reg    <= pcount_next;
            npts_reg      <= npts_next;
            p_reg         <= p_next;
            cnt_reg       <= cnt_next;
            size_reg      <= size_next;
            bofs_reg      <= bofs_next;
            rescale_reg   <= rescale_next;
            rp_reg        <= rp_next;
            tvalid_reg    <= tvalid_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        tlast_reg     <= tlast_next;
        a1_reg        <= a1_next;
        a2_reg        <= a2_next;
        pmul_reg      <= pmul_next;
        pos_reg       <= pos_next;
        prev_end_reg  <= prev_end_next;
        den_reg       <= den_next;
        start_lo_reg  <= start_lo_next;
        hi_reg        <= hi_next;
        l_reg         <= l_next;
        d_neg_reg     <= d_neg_next;
        d_mag_reg     <= d_mag_next;
        prod_reg      <= prod_next;
        peak_reg      <= peak_next;
        v_neg_reg     <= v_neg_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
        rsp_reg       <= rsp_next;
        div_quo_reg   <= div_quo_next;
        div_rem_reg   <= div_rem_next;
        div_dvs_reg   <= div_dvs_next;
    end

endmodule
